>>> src/cse_pkg.sv
// Shared types, constants and codes for the Chebyshev series evaluator.
`default_nettype none

package cse_pkg;

  localparam int CSE_MAX_TERMS = 16;
  localparam int CSE_IDX_W     = $clog2(CSE_MAX_TERMS);
  localparam int CSE_VAL_W     = 32;
  localparam int CSE_TC_W      = 5;
  localparam int CSE_PROD_W    = 64;
  localparam int CSE_ACC_W     = 55;
  localparam int CSE_DIV_CNT_W = 5;
  localparam int CSE_CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CSE_CFG_IDX_W-1:0] CFG_RANGE_MIN  = 2'd0;
  localparam logic [CSE_CFG_IDX_W-1:0] CFG_RANGE_MAX  = 2'd1;
  localparam logic [CSE_CFG_IDX_W-1:0] CFG_TERM_COUNT = 2'd2;

  // request actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_OUTSIDE = 3'd2;
  localparam logic [2:0] ST_WACK    = 3'd3;
  localparam logic [2:0] ST_SAT     = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MULC,
    S_ACC,
    S_TUPD,
    S_FIN,
    S_RESP
  } cse_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cse_div_sts_t;

endpackage

`default_nettype wire

>>> src/cse_coef_bank.sv
// Coefficient register bank: one write port, one read port, cleared by reset.
`default_nettype none

module cse_coef_bank import cse_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        we,
  input  logic [CSE_IDX_W-1:0]        waddr,
  input  logic signed [CSE_VAL_W-1:0] wdata,
  input  logic [CSE_IDX_W-1:0]        raddr,
  output logic signed [CSE_VAL_W-1:0] rdata
);

  logic signed [CSE_VAL_W-1:0] coef_r [CSE_MAX_TERMS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CSE_MAX_TERMS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (we) begin
      coef_r[waddr] <= wdata;
    end
  end

  assign rdata = coef_r[raddr];

endmodule

`default_nettype wire

>>> src/cse_div.sv
// Restoring divider, one quotient bit a cycle: q = (d*2^31 + r/2) / r.
`default_nettype none

module cse_div import cse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [31:0]          num_d,
  input  logic [31:0]          den_r,
  output logic [31:0]          quo,
  output cse_div_sts_t         sts
);

  logic [31:0]              rem_r;
  logic [31:0]              quo_r;
  logic [31:0]              div_r;
  logic [CSE_DIV_CNT_W-1:0] cnt_r;
  logic                     run_r;
  logic                     done_r;

  logic [32:0] trial;
  logic        ge;
  logic [32:0] diff;

  // dividend is {d, r[31:1]}; its top 31 bits seed the remainder
  assign trial = {rem_r, quo_r[31]};
  assign ge    = (trial >= {1'b0, div_r});
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (&cnt_r) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num_d[31:1]};
      quo_r <= {num_d[0], den_r[31:1]};
      div_r <= den_r;
    end else if (run_r) begin
      rem_r <= ge ? diff[31:0] : trial[31:0];
      quo_r <= {quo_r[30:0], ge};
    end
  end

  assign quo      = quo_r;
  assign sts.busy = run_r;
  assign sts.done = done_r;

endmodule

`default_nettype wire

>>> src/cse_mul.sv
// Shared signed 32x32 multiplier with registered product.
`default_nettype none

module cse_mul import cse_pkg::*; (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [CSE_VAL_W-1:0]  op_a,
  input  logic signed [CSE_VAL_W-1:0]  op_b,
  output logic signed [CSE_PROD_W-1:0] prod
);

  logic signed [CSE_PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

>>> src/chebyshev_series_eval.sv
// Top level of the Chebyshev series evaluator: control sequencer and datapath.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in_     | request   | in_valid / in_ready  | action, coef_index, coef_value, sample_x
//  out_    | result    | out_valid / out_ready| result_value, status
//  cfg_    | config    | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// Writes and early outs (empty range, no terms, sample outside) go directly to the
// result state. An evaluation runs division, then multiply, accumulate and recurrence
// steps per term, then rounding and the output load. One request at a
// time: in_ready only in idle, back with out_valid. A waiting result lets the next
// request in; only the result after it stalls on out_ready low.
// Reset (rst_n, synchronous) clears sequencer, coefficient bank, term count, range min.
`default_nettype none

module chebyshev_series_eval import cse_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [CSE_IDX_W-1:0]        in_coef_index,
  input  logic signed [CSE_VAL_W-1:0] in_coef_value,
  input  logic signed [CSE_VAL_W-1:0] in_sample_x,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [CSE_VAL_W-1:0] out_result_value,
  output logic [2:0]                  out_status,
  // configuration
  input  logic                        cfg_we,
  input  logic [CSE_CFG_IDX_W-1:0]    cfg_index,
  input  logic [CSE_VAL_W-1:0]        cfg_wdata
);

  localparam logic signed [CSE_VAL_W-1:0] Q30_ONE = 32'sh4000_0000;
  localparam logic signed [CSE_VAL_W-1:0] T_HI    = 32'sh7fff_ffff;
  localparam logic signed [CSE_VAL_W-1:0] T_LO    = 32'sh8000_0000;

  // configuration registers
  logic signed [CSE_VAL_W-1:0] range_min_r;
  logic signed [CSE_VAL_W-1:0] range_max_r;
  logic [CSE_TC_W-1:0]         term_count_r;

  // sequencer
  cse_state_t state_r, state_nxt;

  // datapath registers
  logic signed [CSE_VAL_W-1:0] t_r;
  logic signed [CSE_VAL_W-1:0] tcur_r;
  logic signed [CSE_VAL_W-1:0] tprev_r;
  logic signed [CSE_ACC_W-1:0] acc_r;
  logic [CSE_IDX_W-1:0]        k_r;
  logic [CSE_IDX_W-1:0]        n_m1_r;
  logic signed [CSE_VAL_W-1:0] pend_val_r;
  logic [2:0]                  pend_sts_r;
  logic                        out_valid_r;
  logic signed [CSE_VAL_W-1:0] out_val_r;
  logic [2:0]                  out_sts_r;

  // request checks
  logic                  accept;
  logic signed [32:0]    span;
  logic                  empty;
  logic                  outside;
  logic [CSE_TC_W-1:0]   n_eff;
  logic [CSE_VAL_W-1:0]  sample_ofs;

  // shared units
  logic                         div_start;
  logic [31:0]                  div_q;
  cse_div_sts_t                 div_sts;
  logic                         mul_en;
  logic signed [CSE_VAL_W-1:0]  mul_a;
  logic signed [CSE_VAL_W-1:0]  mul_b;
  logic signed [CSE_PROD_W-1:0] prod;
  logic                         bank_we;
  logic signed [CSE_VAL_W-1:0]  coef_rd;

  // recurrence and rounding
  logic signed [65:0]           rec_sum;
  logic signed [36:0]           rec_diff;
  logic signed [CSE_VAL_W-1:0]  t_next;
  logic signed [CSE_ACC_W-1:0]  term_add;
  logic signed [CSE_ACC_W:0]    rnd_sum;
  logic signed [39:0]           rnd_res;
  logic                         load_out;
  logic                         last_term;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == S_RESP) && (!out_valid_r || out_ready);

  assign span    = {range_max_r[31], range_max_r} - {range_min_r[31], range_min_r};
  assign empty   = span[32] || (span == '0);
  assign outside = (in_sample_x < range_min_r) || (in_sample_x > range_max_r);
  assign n_eff   = (term_count_r > CSE_TC_W'(CSE_MAX_TERMS)) ?
                   CSE_TC_W'(CSE_MAX_TERMS) : term_count_r;
  assign sample_ofs = in_sample_x - range_min_r;

  assign last_term = (k_r == n_m1_r);

  // T_k = floor((2 t T_{k-1} + 2^29) / 2^30) - T_{k-2}, clamped to 32 bits
  assign rec_sum  = {prod[63], prod, 1'b0} + 66'sh2000_0000;
  assign rec_diff = {rec_sum[65], rec_sum[65:30]} - {{5{tprev_r[31]}}, tprev_r};
  always_comb begin
    if (!rec_diff[36] && (|rec_diff[35:31])) begin
      t_next = T_HI;
    end else if (rec_diff[36] && !(&rec_diff[35:31])) begin
      t_next = T_LO;
    end else begin
      t_next = rec_diff[31:0];
    end
  end

  assign term_add = {{5{prod[63]}}, prod[63:14]};
  assign rnd_sum  = {acc_r[CSE_ACC_W-1], acc_r} + (CSE_ACC_W+1)'(32768);
  assign rnd_res  = rnd_sum[55:16];

  cse_coef_bank u_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (bank_we),
    .waddr (in_coef_index),
    .wdata (in_coef_value),
    .raddr (k_r),
    .rdata (coef_rd)
  );

  cse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num_d (sample_ofs),
    .den_r (span[31:0]),
    .quo   (div_q),
    .sts   (div_sts)
  );

  cse_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACT_EVAL && !empty && (n_eff != '0) && !outside) begin
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_DIV:  if (div_sts.done) state_nxt = S_MULC;
      S_MULC: state_nxt = S_ACC;
      S_ACC: begin
        if (last_term) begin
          state_nxt = S_FIN;
        end else if (k_r == '0) begin
          state_nxt = S_MULC;
        end else begin
          state_nxt = S_TUPD;
        end
      end
      S_TUPD: state_nxt = S_MULC;
      S_FIN:  state_nxt = S_RESP;
      S_RESP: if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    div_start = 1'b0;
    bank_we   = 1'b0;
    mul_en    = 1'b0;
    mul_a     = t_r;
    mul_b     = tcur_r;
    unique case (state_r)
      S_IDLE: begin
        bank_we   = accept && (in_action == ACT_WRITE);
        div_start = accept && (in_action == ACT_EVAL) && !empty &&
                    (n_eff != '0) && !outside;
      end
      S_MULC: begin
        mul_en = 1'b1;
        mul_a  = coef_rd;
      end
      S_ACC:  mul_en = 1'b1;   // t * T_k for the next recurrence step
      S_DIV, S_TUPD, S_FIN, S_RESP: begin
        mul_en = 1'b0;
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      range_min_r  <= '0;
      range_max_r  <= 32'sd65536;
      term_count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_RANGE_MIN:  range_min_r  <= cfg_wdata;
          CFG_RANGE_MAX:  range_max_r  <= cfg_wdata;
          CFG_TERM_COUNT: term_count_r <= cfg_wdata[CSE_TC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        pend_val_r <= '0;
        acc_r      <= '0;
        k_r        <= '0;
        n_m1_r     <= CSE_IDX_W'(n_eff - 1'b1);
        if (in_action == ACT_WRITE) begin
          pend_sts_r <= ST_WACK;
        end else if (empty) begin
          pend_sts_r <= ST_EMPTY;
        end else if (n_eff == '0) begin
          pend_sts_r <= ST_OK;
        end else begin
          pend_sts_r <= ST_OUTSIDE;
        end
      end
      S_DIV: begin
        t_r    <= div_q - Q30_ONE;
        tcur_r <= Q30_ONE;
      end
      S_ACC: begin
        acc_r <= acc_r + term_add;
        if (!last_term) begin
          k_r <= k_r + 1'b1;
          if (k_r == '0) begin
            tprev_r <= tcur_r;
            tcur_r  <= t_r;
          end
        end
      end
      S_TUPD: begin
        tprev_r <= tcur_r;
        tcur_r  <= t_next;
      end
      S_FIN: begin
        if (!rnd_res[39] && (|rnd_res[38:31])) begin
          pend_val_r <= T_HI;
          pend_sts_r <= ST_SAT;
        end else if (rnd_res[39] && !(&rnd_res[38:31])) begin
          pend_val_r <= T_LO;
          pend_sts_r <= ST_SAT;
        end else begin
          pend_val_r <= rnd_res[31:0];
          pend_sts_r <= ST_OK;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_val_r <= pend_val_r;
      out_sts_r <= pend_sts_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_val_r;
  assign out_status       = out_sts_r;

  // divider reports completion only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_DIV))
    else $error("divider done outside division phase");

  // a coefficient write goes straight to the result stage
  a_write_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == ACT_WRITE) |=> (state_r == S_RESP))
    else $error("coefficient write did not go to result stage");

  // term index never passes the last term
  a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MULC || state_r == S_ACC || state_r == S_TUPD) |-> (k_r <= n_m1_r))
    else $error("term index beyond term count");

  // saturated results carry a rail value
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sts_r == ST_SAT) |-> (out_val_r == T_HI || out_val_r == T_LO))
    else $error("saturation status without rail value");

endmodule

`default_nettype wire
